>>> src/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// shared widths, register indexes and stage payload types of the primary
// ray direction pipeline
// ----------------------------------------------------------------------------
package prd_pkg;

  // field widths
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned SUB_W     = 8;
  localparam int unsigned INV_W     = 25;
  localparam int unsigned ROW_W     = 60;
  localparam int unsigned LANE_W    = 20;
  localparam int unsigned DIR_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // internal widths
  localparam int unsigned NDC_W     = 24;  // Q.20 ndc in [-4, 4]
  localparam int unsigned NDC_FRAC  = 20;
  localparam int unsigned MAG_W     = 30;  // normalized magnitude, msb at bit 29
  localparam int unsigned SUM_W     = 62;  // sum of three squares
  localparam int unsigned LEN_W     = 31;  // floor square root of the sum
  localparam int unsigned NUM_W     = 46;  // divider numerator
  localparam int unsigned Q_W       = 16;  // quotient bits

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_H   = 3'd4;

  localparam logic [INV_W-1:0] INV_RESET = 25'h100_0000;

  typedef logic [2:0][ROW_W-1:0] basis_t;

  typedef struct packed {
    logic signed [NDC_W-1:0] nx;
    logic signed [NDC_W-1:0] ny;
  } ndc_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
  } lane_t;

  typedef struct packed {
    lane_t            ln;
    logic [SUM_W-1:0] sum;
  } vec_t;

endpackage

>>> src/prd_ndc.sv
// ----------------------------------------------------------------------------
// prd_ndc
// pixel plus sub-pixel offset to normalized device coordinates, two stages
// ----------------------------------------------------------------------------
module prd_ndc #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [prd_pkg::PIX_W-1:0]          pixel_x,
  input  logic [prd_pkg::PIX_W-1:0]          pixel_y,
  input  logic [prd_pkg::SUB_W-1:0]          sub_x,
  input  logic [prd_pkg::SUB_W-1:0]          sub_y,
  input  logic [prd_pkg::INV_W-1:0]          inv_w,
  input  logic [prd_pkg::INV_W-1:0]          inv_h,
  output logic                               ndc_valid,
  output prd_pkg::ndc_t                      ndc
);

  localparam int unsigned PIX_LIM = (MAX_DIM > 4096) ? 4095 : MAX_DIM - 1;
  localparam logic [prd_pkg::PIX_W-1:0] PIX_MAX = prd_pkg::PIX_W'(PIX_LIM);
  localparam int unsigned COORD_W = prd_pkg::PIX_W + prd_pkg::SUB_W;
  localparam int unsigned PROD_W = COORD_W + prd_pkg::INV_W;
  localparam int unsigned V_W = 48;
  localparam logic signed [V_W-1:0] ONE_Q32 = 48'sd4294967296;
  localparam logic signed [V_W-1:0] NDC_LIM = 48'sd17179869184;

  // clamp, round half up to Q.20
  function automatic logic signed [prd_pkg::NDC_W-1:0] ndc_round(
    input logic signed [V_W-1:0] v
  );
    logic signed [V_W-1:0] c;
    logic [V_W-1:0] u;
    c = v;
    if (c > NDC_LIM) begin
      c = NDC_LIM;
    end else if (c < -NDC_LIM) begin
      c = -NDC_LIM;
    end
    u = c + NDC_LIM;
    u = (u + 48'd2048) >> 12;
    return u[prd_pkg::NDC_W-1:0] - 24'd4194304;
  endfunction

  logic [prd_pkg::PIX_W-1:0] px, py;
  logic [COORD_W-1:0]        cx, cy;
  logic [PROD_W-1:0]         prodx_nxt, prody_nxt;
  logic [PROD_W-1:0]         prodx_r, prody_r;
  logic                      v1_r, v2_r;
  logic signed [V_W-1:0]     vx, vy;
  prd_pkg::ndc_t             ndc_nxt, ndc_r;

  // stage 1: clamp pixel, scale by film reciprocal
  assign px = (pixel_x > PIX_MAX) ? PIX_MAX : pixel_x;
  assign py = (pixel_y > PIX_MAX) ? PIX_MAX : pixel_y;
  assign cx = {px, sub_x};
  assign cy = {py, sub_y};
  assign prodx_nxt = PROD_W'(cx) * PROD_W'(inv_w);
  assign prody_nxt = PROD_W'(cy) * PROD_W'(inv_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prodx_r <= prodx_nxt;
      prody_r <= prody_nxt;
    end
  end

  // stage 2: map to -1..1, y flipped
  assign vx = $signed({2'b00, prodx_r, 1'b0}) - ONE_Q32;
  assign vy = ONE_Q32 - $signed({2'b00, prody_r, 1'b0});
  assign ndc_nxt.nx = ndc_round(vx);
  assign ndc_nxt.ny = ndc_round(vy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ndc_r <= ndc_nxt;
    end
  end

  assign ndc_valid = v2_r;
  assign ndc       = ndc_r;

endmodule

>>> src/prd_basis.sv
// ----------------------------------------------------------------------------
// prd_basis
// 3x3 basis transform, magnitude normalization and sum of squares
// ----------------------------------------------------------------------------
module prd_basis (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            ndc_valid,
  input  prd_pkg::ndc_t   ndc,
  input  prd_pkg::basis_t basis,
  output logic            vec_valid,
  output prd_pkg::vec_t   vec
);

  localparam int unsigned LANE_W = prd_pkg::LANE_W;
  localparam int unsigned ROW_W = prd_pkg::ROW_W;
  localparam int unsigned MUL_W = LANE_W + prd_pkg::NDC_W;
  localparam int unsigned ACC_W = MUL_W + 2;
  localparam int unsigned MSB_W = $clog2(ACC_W);
  localparam int unsigned MAG_W = prd_pkg::MAG_W;
  localparam int unsigned SQ_W = 2 * MAG_W;
  localparam logic [MSB_W-1:0] MAG_TOP = MSB_W'(MAG_W - 1);

  function automatic logic signed [LANE_W-1:0] lane_of(
    input logic [ROW_W-1:0] row,
    input int unsigned k
  );
    return row[k*LANE_W +: LANE_W];
  endfunction

  logic signed [MUL_W-1:0] xp_r [3];
  logic signed [MUL_W-1:0] yp_r [3];
  logic signed [ACC_W-1:0] w_r [3];
  logic [ACC_W-1:0]        mag5_r [3];
  logic [ACC_W-1:0]        mag6_r [3];
  logic [MAG_W-1:0]        mag7_r [3];
  logic [MAG_W-1:0]        mag8_r [3];
  logic [SQ_W-1:0]         sq8_r [3];
  logic [ACC_W-1:0]        mag_or;
  logic [MSB_W-1:0]        msb_nxt, msb6_r;
  logic [ACC_W-1:0]        shifted [3];
  logic [2:0]              neg5_r, neg6_r, neg7_r, neg8_r;
  logic                    zero6_r, zero7_r, zero8_r;
  logic                    v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  prd_pkg::vec_t           vec_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v3_r <= ndc_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  // or of all magnitudes shares the msb of the largest
  assign mag_or = mag5_r[0] | mag5_r[1] | mag5_r[2];

  // leading one of the or of all magnitudes
  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < ACC_W; i++) begin
      if (mag_or[i]) begin
        msb_nxt = MSB_W'(i);
      end
    end
  end

  // common shift puts the largest magnitude in [2^29, 2^30)
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (msb6_r >= MAG_TOP) begin
        shifted[r] = mag6_r[r] >> (msb6_r - MAG_TOP);
      end else begin
        shifted[r] = mag6_r[r] << (MAG_TOP - msb6_r);
      end
    end
  end

  // datapath stages 3 to 9
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        xp_r[r] <= MUL_W'(lane_of(basis[r], 0)) * MUL_W'(ndc.nx);
        yp_r[r] <= MUL_W'(lane_of(basis[r], 1)) * MUL_W'(ndc.ny);
        w_r[r] <= ACC_W'(xp_r[r]) + ACC_W'(yp_r[r]) +
                  (ACC_W'(lane_of(basis[r], 2)) <<< prd_pkg::NDC_FRAC);
        mag5_r[r] <= w_r[r][ACC_W-1] ? ACC_W'(-w_r[r]) : w_r[r];
        neg5_r[r] <= w_r[r][ACC_W-1];
        mag6_r[r] <= mag5_r[r];
        mag7_r[r] <= shifted[r][MAG_W-1:0];
        mag8_r[r] <= mag7_r[r];
        sq8_r[r] <= SQ_W'(mag7_r[r]) * SQ_W'(mag7_r[r]);
      end
      msb6_r  <= msb_nxt;
      zero6_r <= (mag_or == '0);
      neg6_r  <= neg5_r;
      zero7_r <= zero6_r;
      neg7_r  <= neg6_r;
      zero8_r <= zero7_r;
      neg8_r  <= neg7_r;
      for (int r = 0; r < 3; r++) begin
        vec_r.ln.mag[r] <= mag8_r[r];
      end
      vec_r.ln.neg  <= neg8_r;
      vec_r.ln.zero <= zero8_r;
      vec_r.sum     <= prd_pkg::SUM_W'(sq8_r[0]) + prd_pkg::SUM_W'(sq8_r[1]) +
                       prd_pkg::SUM_W'(sq8_r[2]);
    end
  end

  assign vec_valid = v9_r;
  assign vec       = vec_r;

endmodule

>>> src/prd_rsqrt.sv
// ----------------------------------------------------------------------------
// prd_rsqrt
// pipelined integer square root, one result bit a stage, then a pipelined
// rounded divide of each magnitude by the length and saturation to Q1.15
// ----------------------------------------------------------------------------
module prd_rsqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vec_valid,
  input  prd_pkg::vec_t                    vec,
  output logic                             out_valid,
  output logic signed [prd_pkg::DIR_W-1:0] dir_x,
  output logic signed [prd_pkg::DIR_W-1:0] dir_y,
  output logic signed [prd_pkg::DIR_W-1:0] dir_z
);

  localparam int unsigned SQ_N = prd_pkg::LEN_W;
  localparam int unsigned SUM_W = prd_pkg::SUM_W;
  localparam int unsigned LEN_W = prd_pkg::LEN_W;
  localparam int unsigned NUM_W = prd_pkg::NUM_W;
  localparam int unsigned Q_W = prd_pkg::Q_W;
  localparam int unsigned DIR_W = prd_pkg::DIR_W;
  localparam int unsigned FRAC = DIR_W - 1;
  localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 16'h8000;

  // square root stages
  logic                  sq_v_r [1:SQ_N];
  logic [SUM_W-1:0]      sq_rem_r [1:SQ_N];
  logic [SUM_W-1:0]      sq_res_r [1:SQ_N];
  prd_pkg::lane_t        sq_ln_r [1:SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (2 * (SQ_N - 1 - k));
    logic             v_in;
    logic [SUM_W-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;
    prd_pkg::lane_t   ln_in;

    if (k == 0) begin : g_head
      assign v_in   = vec_valid;
      assign rem_in = vec.sum;
      assign res_in = '0;
      assign ln_in  = vec.ln;
    end else begin : g_body
      assign v_in   = sq_v_r[k];
      assign rem_in = sq_rem_r[k];
      assign res_in = sq_res_r[k];
      assign ln_in  = sq_ln_r[k];
    end

    // one restoring step
    always_comb begin
      trial = res_in + STEP_BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + STEP_BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1] <= rem_nxt;
        sq_res_r[k+1] <= res_nxt;
        sq_ln_r[k+1]  <= ln_in;
      end
    end
  end

  // numerator setup: mag * 2^15 + len / 2
  logic [LEN_W-1:0]            len;
  logic                        nm_v_r;
  logic [2:0][NUM_W-1:0]       nm_rem_r;
  logic [LEN_W-1:0]            nm_len_r;
  prd_pkg::lane_t              nm_ln_r;

  assign len = sq_res_r[SQ_N][LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
    end else if (en) begin
      nm_v_r <= sq_v_r[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nm_rem_r[i] <= NUM_W'({sq_ln_r[SQ_N].mag[i], FRAC'(0)}) +
                       NUM_W'(len[LEN_W-1:1]);
      end
      nm_len_r <= len;
      nm_ln_r  <= sq_ln_r[SQ_N];
    end
  end

  // divide stages, one quotient bit each
  logic                  dv_v_r [1:Q_W];
  logic [2:0][NUM_W-1:0] dv_rem_r [1:Q_W];
  logic [2:0][Q_W-1:0]   dv_q_r [1:Q_W];
  logic [LEN_W-1:0]      dv_len_r [1:Q_W];
  prd_pkg::lane_t        dv_ln_r [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_dv
    localparam int unsigned QB = Q_W - 1 - k;
    logic                  v_in;
    logic [2:0][NUM_W-1:0] rem_in, rem_nxt;
    logic [2:0][Q_W-1:0]   q_in, q_nxt;
    logic [LEN_W-1:0]      len_in;
    logic [NUM_W-1:0]      cmp;
    prd_pkg::lane_t        ln_in;

    if (k == 0) begin : g_head
      assign v_in   = nm_v_r;
      assign rem_in = nm_rem_r;
      assign q_in   = '0;
      assign len_in = nm_len_r;
      assign ln_in  = nm_ln_r;
    end else begin : g_body
      assign v_in   = dv_v_r[k];
      assign rem_in = dv_rem_r[k];
      assign q_in   = dv_q_r[k];
      assign len_in = dv_len_r[k];
      assign ln_in  = dv_ln_r[k];
    end

    assign cmp = NUM_W'(len_in) << QB;

    // compare and subtract per lane
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= cmp) begin
          rem_nxt[i] = rem_in[i] - cmp;
          q_nxt[i]   = q_in[i] | (Q_W'(1) << QB);
        end else begin
          rem_nxt[i] = rem_in[i];
          q_nxt[i]   = q_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= rem_nxt;
        dv_q_r[k+1]   <= q_nxt;
        dv_len_r[k+1] <= len_in;
        dv_ln_r[k+1]  <= ln_in;
      end
    end
  end

  // sign, saturation and zero vector into the output register
  logic                  out_v_r;
  logic [2:0][DIR_W-1:0] dir_nxt, dir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_ln_r[Q_W].zero) begin
        dir_nxt[i] = '0;
      end else if (dv_ln_r[Q_W].neg[i]) begin
        if (dv_q_r[Q_W][i] > Q_NEG_MAX) begin
          dir_nxt[i] = Q_NEG_MAX;
        end else begin
          dir_nxt[i] = DIR_W'(~dv_q_r[Q_W][i] + Q_W'(1));
        end
      end else begin
        if (dv_q_r[Q_W][i] > Q_POS_MAX) begin
          dir_nxt[i] = Q_POS_MAX;
        end else begin
          dir_nxt[i] = dv_q_r[Q_W][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r <= dir_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign dir_x     = $signed(dir_r[0]);
  assign dir_y     = $signed(dir_r[1]);
  assign dir_z     = $signed(dir_r[2]);

endmodule

>>> src/primary_ray_direction.sv
// ----------------------------------------------------------------------------
// primary_ray_direction
// pinhole camera primary ray: pixel and sub-pixel offset to a unit direction
// in signed Q1.15 through a configured 3x3 basis
// ----------------------------------------------------------------------------
//  channel  | ports                                   | flow
//  ---------+-----------------------------------------+-------------------
//  input    | in_valid/in_ready, pixel_*, sub_*       | valid/ready
//  output   | out_valid/out_ready, out_dir_x/y/z      | valid/ready
//  config   | cfg_we, cfg_idx, cfg_wdata              | write only
//
// one transaction per cycle sustained while the output is not stalled; the
// pipeline runs through the ndc stages, the basis and squares stages, 31 square
// root steps, the numerator register, 16 divide steps and the output register.
// the square root and divide pipelines, one result bit per stage, set the depth.
// reset is synchronous and clears only valid bits and configuration.
// a stalled output freezes the whole pipeline; in_ready follows it.
// ----------------------------------------------------------------------------
module primary_ray_direction #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [prd_pkg::PIX_W-1:0]           in_pixel_x,
  input  logic [prd_pkg::PIX_W-1:0]           in_pixel_y,
  input  logic [prd_pkg::SUB_W-1:0]           in_sub_x,
  input  logic [prd_pkg::SUB_W-1:0]           in_sub_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [prd_pkg::DIR_W-1:0]    out_dir_x,
  output logic signed [prd_pkg::DIR_W-1:0]    out_dir_y,
  output logic signed [prd_pkg::DIR_W-1:0]    out_dir_z,
  input  logic                                cfg_we,
  input  logic [prd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [prd_pkg::ROW_W-1:0]           cfg_wdata
);

  prd_pkg::basis_t               basis_r;
  logic [prd_pkg::INV_W-1:0]     inv_w_r, inv_h_r;
  logic                          en;
  logic                          ndc_valid, vec_valid;
  prd_pkg::ndc_t                 ndc;
  prd_pkg::vec_t                 vec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r <= '0;
      inv_w_r <= prd_pkg::INV_RESET;
      inv_h_r <= prd_pkg::INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        prd_pkg::CFG_BASIS_X: basis_r[0] <= cfg_wdata;
        prd_pkg::CFG_BASIS_Y: basis_r[1] <= cfg_wdata;
        prd_pkg::CFG_BASIS_Z: basis_r[2] <= cfg_wdata;
        prd_pkg::CFG_INV_W:   inv_w_r <= cfg_wdata[prd_pkg::INV_W-1:0];
        prd_pkg::CFG_INV_H:   inv_h_r <= cfg_wdata[prd_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  prd_ndc #(
    .MAX_DIM (MAX_DIM)
  ) u_ndc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .pixel_x   (in_pixel_x),
    .pixel_y   (in_pixel_y),
    .sub_x     (in_sub_x),
    .sub_y     (in_sub_y),
    .inv_w     (inv_w_r),
    .inv_h     (inv_h_r),
    .ndc_valid (ndc_valid),
    .ndc       (ndc)
  );

  prd_basis u_basis (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ndc_valid (ndc_valid),
    .ndc       (ndc),
    .basis     (basis_r),
    .vec_valid (vec_valid),
    .vec       (vec)
  );

  prd_rsqrt u_rsqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vec_valid (vec_valid),
    .vec       (vec),
    .out_valid (out_valid),
    .dir_x     (out_dir_x),
    .dir_y     (out_dir_y),
    .dir_z     (out_dir_z)
  );

endmodule
